/* design/dca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dca_pkg - shared types and constants for the channel allocator
// field widths, stream packing, status codes and controller/datapath links
// ----------------------------------------------------------------------------
package dca_pkg;

    // request and result field widths
    localparam int ID_W      = 5;
    localparam int CH_W      = 4;
    localparam int PRIO_W    = 8;
    localparam int MASK_W    = 16;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // operation codes carried on s_tuser
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFREE   = 2'd1,
        ST_BADID    = 2'd2,
        ST_NOTALLOC = 2'd3
    } status_t;

    // one result beat
    typedef struct packed {
        logic              quiesce_channel;
        logic [PRIO_W-1:0] vector_priority;
        logic              vector_core;
        logic              vector_disable;
        logic              vector_enable;
        logic              assert_engine_reset;
        logic              release_engine_reset;
        logic [CH_W-1:0]   granted_channel;
        status_t           status;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decide;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } ctrl_sts_t;

endpackage

`default_nettype wire

/* design/dca_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dca_ctrl - request sequencer
// steps each request through capture, decide and commit
// ----------------------------------------------------------------------------
module dca_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output dca_pkg::ctrl_cmd_t      cmd,
    input  wire dca_pkg::ctrl_sts_t sts
);
    import dca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECIDE = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   commit_ok;

    assign commit_ok  = (state_reg == S_COMMIT) && !sts.out_stall;
    // a new beat may enter in the same cycle the previous one commits
    assign s_tready   = (state_reg == S_IDLE) || commit_ok;
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.decide = (state_reg == S_DECIDE);
    assign cmd.commit = commit_ok;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit_ok) begin
                    state_next = cmd.load ? S_DECIDE : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_load_to_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.load) |=> (state_reg == S_DECIDE))
        else $error("accepted beat did not move to decide");

    a_decide_to_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && state_reg == S_DECIDE) |=> (state_reg == S_COMMIT))
        else $error("decide not followed by commit");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && state_reg == S_COMMIT && sts.out_stall) |=> (state_reg == S_COMMIT))
        else $error("commit left while output stalled");
`endif

endmodule

`default_nettype wire

/* design/dca_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dca_datapath - ownership masks, lowest-free search and result register
// decides a request from the masks, then commits the mask update and flags
// ----------------------------------------------------------------------------
module dca_datapath #(
    parameter int CHANNELS = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire dca_pkg::ctrl_cmd_t              cmd,
    output dca_pkg::ctrl_sts_t                   sts,
    input  wire logic [dca_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dca_pkg::M_TDATA_W-1:0]        m_tdata
);
    import dca_pkg::*;

    localparam logic [ID_W-1:0] CHAN_ID = ID_W'(CHANNELS);

    // captured request
    logic              op_reg;
    logic [ID_W-1:0]   id_reg;
    logic              core_reg;
    logic [PRIO_W-1:0] prio_reg;

    // decision
    status_t           st_reg;
    status_t           st_next;
    logic [CH_W-1:0]   ch_reg;
    logic [CH_W-1:0]   ch_next;

    // ownership
    logic [CHANNELS-1:0] core0_owned_reg;
    logic [CHANNELS-1:0] core0_owned_next;
    logic [CHANNELS-1:0] core1_owned_reg;
    logic [CHANNELS-1:0] core1_owned_next;

    result_t res_reg;
    result_t res_next;
    logic    m_valid_reg;

    logic [CHANNELS-1:0] taken;
    logic [MASK_W-1:0]   taken_ext;
    logic                lf_found;
    logic [CH_W-1:0]     lf_idx;
    logic [MASK_W-1:0]   bit_ext;
    logic [CHANNELS-1:0] bitm;

    assign taken     = core0_owned_reg | core1_owned_reg;
    assign taken_ext = MASK_W'(taken);

    // lowest free channel
    always_comb begin
        lf_found = 1'b0;
        lf_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!taken[i]) begin
                lf_found = 1'b1;
                lf_idx   = CH_W'(i);
            end
        end
    end

    always_comb begin
        st_next = ST_OK;
        ch_next = id_reg[CH_W-1:0];
        if (op_reg == CMD_ALLOC) begin
            if (id_reg > CHAN_ID) begin
                st_next = ST_BADID;
            end else if (id_reg < CHAN_ID) begin
                st_next = taken_ext[id_reg[CH_W-1:0]] ? ST_NOFREE : ST_OK;
            end else begin
                ch_next = lf_idx;
                st_next = lf_found ? ST_OK : ST_NOFREE;
            end
        end else begin
            if (id_reg >= CHAN_ID) begin
                st_next = ST_BADID;
            end else begin
                st_next = taken_ext[id_reg[CH_W-1:0]] ? ST_OK : ST_NOTALLOC;
            end
        end
    end

    assign bit_ext = MASK_W'(1) << ch_reg;
    assign bitm    = bit_ext[CHANNELS-1:0];

    // mask update and event flags
    always_comb begin
        core0_owned_next = core0_owned_reg;
        core1_owned_next = core1_owned_reg;
        res_next         = '0;
        res_next.status  = st_reg;
        if (st_reg == ST_OK) begin
            res_next.granted_channel = ch_reg;
            if (op_reg == CMD_ALLOC) begin
                res_next.release_engine_reset = (taken == '0);
                if (core_reg == 1'b0) begin
                    res_next.vector_enable = (core0_owned_reg == '0);
                    core0_owned_next       = core0_owned_reg | bitm;
                end else begin
                    res_next.vector_enable = (core1_owned_reg == '0);
                    res_next.vector_core   = (core1_owned_reg == '0);
                    core1_owned_next       = core1_owned_reg | bitm;
                end
                res_next.vector_priority = res_next.vector_enable ? prio_reg : '0;
            end else begin
                res_next.quiesce_channel = 1'b1;
                // core 0 is checked first for ownership
                if ((core0_owned_reg & bitm) != '0) begin
                    core0_owned_next        = core0_owned_reg & ~bitm;
                    res_next.vector_disable = (core0_owned_next == '0);
                end else begin
                    core1_owned_next        = core1_owned_reg & ~bitm;
                    res_next.vector_disable = (core1_owned_next == '0);
                    res_next.vector_core    = (core1_owned_next == '0);
                end
                res_next.assert_engine_reset =
                    ((core0_owned_next | core1_owned_next) == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg   <= s_tdata[ID_W-1:0];
            core_reg <= s_tdata[ID_W];
            prio_reg <= s_tdata[ID_W+PRIO_W:ID_W+1];
            op_reg   <= s_tuser;
        end
        if (cmd.decide) begin
            st_reg <= st_next;
            ch_reg <= ch_next;
        end
        if (cmd.commit) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core0_owned_reg <= '0;
            core1_owned_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.commit) begin
                core0_owned_reg <= core0_owned_next;
                core1_owned_reg <= core1_owned_next;
                m_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_stall = m_valid_reg && !m_tready;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = M_TDATA_W'(res_reg);

`ifndef SYNTHESIS
    a_masks_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (core0_owned_reg & core1_owned_reg) == '0)
        else $error("channel owned by both cores");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.commit) |=> m_valid_reg)
        else $error("committed result not presented");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.status != ST_OK) |->
            (res_reg.granted_channel == '0 && !res_reg.quiesce_channel &&
             !res_reg.vector_enable && !res_reg.vector_disable &&
             !res_reg.release_engine_reset && !res_reg.assert_engine_reset))
        else $error("failed request carries events");
`endif

endmodule

`default_nettype wire

/* design/dual_owner_channel_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_owner_channel_allocator - dma channel allocator shared by two cores
//
// s_ channel: one request beat, operation on s_tuser (0 allocate, 1 free),
//   channel id, requesting core and irq priority in s_tdata
// m_ channel: exactly one result beat per request, status, granted channel
//   and engine / interrupt vector / quiesce events in m_tdata
// path: a taken request is captured, decided, then committed to the output register
// overlap: a new request is taken only when idle or as the last one commits;
//   it is decided against the ownership masks in the decide state, then
//   committed in the commit state; the masks are only updated at commit
// stall: the result sits in an output register; a stalled receiver holds the
//   commit cycle, so at most one decided request waits behind it
// reset: synchronous on aresetn low; both ownership masks clear (no channel
//   taken) and the output register empties
// ----------------------------------------------------------------------------
module dual_owner_channel_allocator #(
    parameter int CHANNELS = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [4:0] channel_id, [5] requesting_core, [13:6] irq_priority, [15:14] zero
    input  wire logic [dca_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [5:2] granted_channel, [6] release_engine_reset,
    // [7] assert_engine_reset, [8] vector_enable, [9] vector_disable,
    // [10] vector_core, [18:11] vector_priority, [19] quiesce_channel,
    // [23:20] zero
    output logic [dca_pkg::M_TDATA_W-1:0]      m_tdata
);
    import dca_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer: capture, decide, commit
    dca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // masks, search and result register
    dca_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the dual-owner dma channel allocator
// requests are queued up front and fed by a falling-edge driver; a
// rising-edge monitor predicts each accepted request against its own pair of
// ownership masks and compares every result beat field by field
// ----------------------------------------------------------------------------
module testbench;
    import dca_pkg::*;

    localparam int CHANNELS       = 12;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int IDLE_PERCENT   = 37;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;

    // channel id value that asks for the lowest free channel
    localparam logic [ID_W-1:0]   ANY_CHANNEL  = ID_W'(CHANNELS);
    localparam logic [MASK_W-1:0] ALL_CHANNELS = MASK_W'((1 << CHANNELS) - 1);
    localparam int                PAD_W        = S_TDATA_W - ID_W - 1 - PRIO_W;

    // one queued request; a marker with wait_for_drain set holds the driver
    // until every outstanding result has come back
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic              core;
        logic [PRIO_W-1:0] prio;
        logic              wait_for_drain;
    } request_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [4:0] channel_id, [5] requesting_core, [13:6] irq_priority, [15:14] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [0] cmd
    logic                 s_tuser  = CMD_ALLOC;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status, [5:2] granted_channel, [6] release_engine_reset,
    // [7] assert_engine_reset, [8] vector_enable, [9] vector_disable,
    // [10] vector_core, [18:11] vector_priority, [19] quiesce_channel,
    // [23:20] zero
    logic [M_TDATA_W-1:0] m_tdata;

    request_t request_queue[$];
    result_t  expected_grants[$];
    request_t next_req;
    result_t  prediction;
    result_t  wanted;
    result_t  got;

    // our own copy of which channels each core holds
    logic [MASK_W-1:0] core_mask [2] = '{'0, '0};

    int issued_count   = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int release_seen = 0;
    int reset_seen   = 0;
    int enable_seen  = 0;
    int disable_seen = 0;
    int quiesce_seen = 0;
    logic calm_stretch;

    dual_owner_channel_allocator #(
        .CHANNELS (CHANNELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // a long window in the middle of the run with no idling on either side
    assign calm_stretch = (accepted_count >= 1000) && (accepted_count < 1300);

    // expected outcome of one request; updates the ownership masks as the
    // block does at commit
    function automatic result_t grant_outcome(input logic cmd,
                                              input logic [ID_W-1:0] id,
                                              input logic core,
                                              input logic [PRIO_W-1:0] prio);
        result_t           r;
        logic [MASK_W-1:0] taken;
        logic [MASK_W-1:0] chan_bit;
        logic [CH_W-1:0]   ch;
        logic              found;
        logic              owner;
        int                i;
        r     = '0;
        taken = (core_mask[0] | core_mask[1]) & ALL_CHANNELS;
        ch    = '0;
        found = 1'b0;
        if (cmd == CMD_ALLOC) begin
            if (id > ANY_CHANNEL) begin
                r.status = ST_BADID;
            end else begin
                if (id < ANY_CHANNEL) begin
                    ch    = id[CH_W-1:0];
                    found = !taken[id[CH_W-1:0]];
                end else begin
                    // scan downward so the lowest free channel wins
                    for (i = CHANNELS - 1; i >= 0; i--) begin
                        if (!taken[i]) begin
                            ch    = CH_W'(i);
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    r.status = ST_NOFREE;
                end else begin
                    chan_bit               = MASK_W'(1) << ch;
                    r.status               = ST_OK;
                    r.granted_channel      = ch;
                    r.release_engine_reset = (taken == '0);
                    if (core_mask[core] == '0) begin
                        r.vector_enable   = 1'b1;
                        r.vector_core     = core;
                        r.vector_priority = prio;
                    end
                    core_mask[core] = core_mask[core] | chan_bit;
                end
            end
        end else begin
            if (id >= ANY_CHANNEL) begin
                r.status = ST_BADID;
            end else begin
                chan_bit = MASK_W'(1) << id;
                if (((core_mask[0] | core_mask[1]) & chan_bit) == '0) begin
                    r.status = ST_NOTALLOC;
                end else begin
                    // the owner comes from the masks, core 0 looked at first
                    owner                 = ((core_mask[0] & chan_bit) != '0) ? 1'b0 : 1'b1;
                    r.status              = ST_OK;
                    r.granted_channel     = id[CH_W-1:0];
                    r.quiesce_channel     = 1'b1;
                    core_mask[owner]      = core_mask[owner] & ~chan_bit;
                    if (core_mask[owner] == '0) begin
                        r.vector_disable = 1'b1;
                        r.vector_core    = owner;
                    end
                    r.assert_engine_reset = ((core_mask[0] | core_mask[1]) == '0);
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $display("%0t ns: mismatch on %s, expected %0d, actual %0d",
                     $time, name, want, seen);
            mismatch_count++;
        end
    endtask

    task automatic queue_request(input logic cmd, input logic [ID_W-1:0] id,
                                 input logic core, input logic [PRIO_W-1:0] prio);
        request_t req;
        req.cmd            = cmd;
        req.id             = id;
        req.core           = core;
        req.prio           = prio;
        req.wait_for_drain = 1'b0;
        request_queue.push_back(req);
    endtask

    // request driver: inputs change on the falling edge; a presented beat is
    // held until the monitor has counted it as accepted
    always @(negedge aclk) begin
        if (aresetn && issued_count == accepted_count) begin
            if (request_queue.size() != 0 && request_queue[0].wait_for_drain) begin
                s_tvalid <= 1'b0;
                if (expected_grants.size() == 0) begin
                    request_queue.delete(0);
                end
            end else if (request_queue.size() != 0 &&
                         (calm_stretch || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
                next_req = request_queue.pop_front();
                s_tuser  <= next_req.cmd;
                s_tdata  <= {PAD_W'(0), next_req.prio, next_req.core, next_req.id};
                s_tvalid <= 1'b1;
                issued_count++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= calm_stretch || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end

    // monitor: result beats are checked before the same edge's request is
    // predicted, so a stray result cannot borrow a fresh expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_grants.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    wanted = expected_grants.pop_front();
                    got    = m_tdata[$bits(result_t)-1:0];
                    check_field("status", 32'(wanted.status), 32'(got.status));
                    check_field("granted_channel", 32'(wanted.granted_channel),
                                32'(got.granted_channel));
                    check_field("release_engine_reset", 32'(wanted.release_engine_reset),
                                32'(got.release_engine_reset));
                    check_field("assert_engine_reset", 32'(wanted.assert_engine_reset),
                                32'(got.assert_engine_reset));
                    check_field("vector_enable", 32'(wanted.vector_enable),
                                32'(got.vector_enable));
                    check_field("vector_disable", 32'(wanted.vector_disable),
                                32'(got.vector_disable));
                    check_field("vector_core", 32'(wanted.vector_core),
                                32'(got.vector_core));
                    check_field("vector_priority", 32'(wanted.vector_priority),
                                32'(got.vector_priority));
                    check_field("quiesce_channel", 32'(wanted.quiesce_channel),
                                32'(got.quiesce_channel));
                    check_field("padding", 0,
                                32'(m_tdata[M_TDATA_W-1:$bits(result_t)]));
                end
            end
            if (s_tvalid && s_tready) begin
                prediction = grant_outcome(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W],
                                           s_tdata[ID_W+PRIO_W:ID_W+1]);
                expected_grants.push_back(prediction);
                accepted_count++;
                status_seen[prediction.status]++;
                release_seen += int'(prediction.release_engine_reset);
                reset_seen   += int'(prediction.assert_engine_reset);
                enable_seen  += int'(prediction.vector_enable);
                disable_seen += int'(prediction.vector_disable);
                quiesce_seen += int'(prediction.quiesce_channel);
            end
        end
    end

    // watchdog: too long without any beat on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** dual_owner_channel_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        request_t          pause_req;
        int                i;
        int                n;
        int                seg_len;
        int                bias;
        int                roll;
        int                alloc_odds;
        logic              cmd;
        logic [ID_W-1:0]   id;

        pause_req                = '0;
        pause_req.wait_for_drain = 1'b1;

        // directed: error paths from an empty pool
        queue_request(CMD_FREE,  5'd0,        1'b0, 8'h00);  // nothing allocated yet
        queue_request(CMD_FREE,  ANY_CHANNEL, 1'b1, 8'hff);  // free at channel count
        queue_request(CMD_FREE,  5'd31,       1'b0, 8'h5a);
        queue_request(CMD_ALLOC, 5'd13,       1'b1, 8'h33);  // just above any
        queue_request(CMD_ALLOC, 5'd31,       1'b0, 8'hff);
        // first grant: engine out of reset, core 0 vector on
        queue_request(CMD_ALLOC, ANY_CHANNEL, 1'b0, 8'hff);
        queue_request(CMD_ALLOC, 5'd0,        1'b1, 8'h12);  // specific, already taken
        queue_request(CMD_ALLOC, 5'd11,       1'b1, 8'h00);  // top channel, core 1 vector on
        queue_request(CMD_ALLOC, ANY_CHANNEL, 1'b1, 8'ha5);
        // free from the other core: owner found from the masks
        queue_request(CMD_FREE,  5'd0,        1'b1, 8'h77);
        queue_request(CMD_FREE,  5'd0,        1'b0, 8'h00);  // second free of the same channel
        queue_request(CMD_FREE,  5'd11,       1'b0, 8'h00);
        queue_request(CMD_FREE,  5'd1,        1'b0, 8'hc3);  // last one: engine back in reset
        // fill the whole pool, then ask once more
        for (i = 0; i < CHANNELS; i++) begin
            queue_request(CMD_ALLOC, ANY_CHANNEL, i[0], PRIO_W'(i * 23));
        end
        queue_request(CMD_ALLOC, ANY_CHANNEL, 1'b0, 8'h81);
        request_queue.push_back(pause_req);

        // random: runs of alloc-heavy, free-heavy or mixed traffic so the pool
        // swings between empty and full, with some out-of-range noise
        n = 0;
        while (n < RANDOM_ITEMS) begin
            seg_len = $urandom_range(40, 8);
            bias    = $urandom_range(2, 0);
            alloc_odds = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
            for (i = 0; i < seg_len; i++) begin
                roll = $urandom_range(99, 0);
                if (roll < 8) begin
                    cmd = 1'($urandom_range(1, 0));
                    id  = (cmd == CMD_ALLOC) ? ID_W'($urandom_range(31, CHANNELS + 1))
                                             : ID_W'($urandom_range(31, CHANNELS));
                end else if ($urandom_range(99, 0) < alloc_odds) begin
                    cmd = CMD_ALLOC;
                    id  = ($urandom_range(99, 0) < 55) ? ANY_CHANNEL
                                                       : ID_W'($urandom_range(CHANNELS - 1, 0));
                end else begin
                    cmd = CMD_FREE;
                    id  = ID_W'($urandom_range(CHANNELS - 1, 0));
                end
                queue_request(cmd, id, 1'($urandom_range(1, 0)),
                              PRIO_W'($urandom_range(255, 0)));
                n++;
                if (n == RANDOM_ITEMS / 3) begin
                    request_queue.push_back(pause_req);
                end
            end
        end

        // single reset at the start
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait out the stimulus and every outstanding result
        while (request_queue.size() != 0 || issued_count != accepted_count ||
               expected_grants.size() != 0) begin
            @(negedge aclk);
        end
        // give a stray late beat a chance to show up
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("covered %0d requests, %0d results: ok %0d, no free %0d, bad id %0d,",
                 accepted_count, result_count, status_seen[ST_OK], status_seen[ST_NOFREE],
                 status_seen[ST_BADID]);
        $display("not allocated %0d; events: engine release %0d, engine reset %0d,",
                 status_seen[ST_NOTALLOC], release_seen, reset_seen);
        $display("vector on %0d, vector off %0d, quiesce %0d",
                 enable_seen, disable_seen, quiesce_seen);
        if (mismatch_count == 0) begin
            $display("** dual_owner_channel_allocator: PASSED **");
        end else begin
            $display("** dual_owner_channel_allocator: FAILED **");
        end
        $finish;
    end

endmodule
